FILE: sv/pnpr_pkg.sv
// package for the parallel nibble packet receiver
// types, codes and constants shared by pnpr_out_if and all modules; no dependencies
`default_nettype none

package pnpr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4,
        PH_ERROR  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        PKT_OK       = 2'd0,
        PKT_CHECKSUM = 2'd1,
        PKT_LENGTH   = 2'd2,
        PKT_TIMEOUT  = 2'd3
    } t_pkt_status;

    // register indexes on the configuration port
    localparam logic [1:0] REG_NIB_WAIT_MAX = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH   = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT  = 2'd2;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [15:0] RST_NIB_WAIT_MAX = 16'd3000;
    localparam logic [15:0] RST_MAX_LENGTH   = 16'd1514;
    localparam logic [3:0]  RST_RETRY_LIMIT  = 4'd3;

    // pin patterns and drive values
    localparam logic [4:0]  START_PATTERN = 5'h18;
    localparam logic [4:0]  ERROR_EXIT    = 5'h10;
    localparam logic [4:0]  DRIVE_NONE    = 5'h00;
    localparam logic [4:0]  DRIVE_START   = 5'h01;
    localparam logic [4:0]  DRIVE_ACK     = 5'h10;
    localparam logic [15:0] MIN_LENGTH    = 16'd8;

    typedef struct packed {
        logic [15:0] nib_wait_max;
        logic [15:0] max_length;
        logic [3:0]  retry_limit;
    } t_cfg;

endpackage : pnpr_pkg

`default_nettype wire

FILE: sv/pnpr_if.sv
// valid/ready channel interfaces of the receiver: tick samples in, results out
// depends on pnpr_pkg for the status code type
`default_nettype none

interface pnpr_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] status_bits;

    modport source (output valid, output status_bits, input ready);
    modport sink   (input valid, input status_bits, output ready);
endinterface : pnpr_in_if

interface pnpr_out_if;
    logic                 valid;
    logic                 ready;
    logic [4:0]           port_drive;
    logic                 data_valid;
    logic [7:0]           data_byte;
    logic                 packet_done;
    pnpr_pkg::t_pkt_status packet_status;
    logic [15:0]          packet_length;
    logic                 receiving;

    modport source (output valid, output port_drive, output data_valid, output data_byte,
                    output packet_done, output packet_status, output packet_length,
                    output receiving, input ready);
    modport sink   (input valid, input port_drive, input data_valid, input data_byte,
                    input packet_done, input packet_status, input packet_length,
                    input receiving, output ready);
endinterface : pnpr_out_if

`default_nettype wire

FILE: sv/parallel_nibble_packet_receiver.sv
// top level of the parallel nibble packet receiver
// depends on pnpr_pkg, pnpr_if, pnpr_cfg_regs and pnpr_core
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        status_bits[4:0], one pin sample per tick
//   o_out     out  valid/ready        port_drive, data_valid, data_byte,
//                                     packet_done, packet_status, packet_length, receiving
//   apb       in   psel/penable       nib_wait_max @0x0, max_length @0x4, retry_limit @0x8
//
// one item per cycle while the sink keeps up: a tick goes through the frame state logic
// in the accept cycle and its result sits in the output register from the next cycle
// a new item is taken whenever the output register is empty or being emptied, so a
// stalled sink holds exactly one result and back-pressures the sample stream
// synchronous active-low reset returns to idle with all counters cleared and the
// configuration registers at 3000, 1514 and 3
`default_nettype none

module parallel_nibble_packet_receiver (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    pnpr_in_if.sink                             i_in,
    pnpr_out_if.source                          o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pnpr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pnpr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pnpr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import pnpr_pkg::*;

    // live configuration, writes land at once
    t_cfg cfg;

    pnpr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // frame state, nibble handshake, timeout tally and the result register
    pnpr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule : parallel_nibble_packet_receiver

`default_nettype wire

FILE: sv/pnpr_cfg_regs.sv
// apb-style configuration registers of the receiver
// depends on pnpr_pkg
`default_nettype none

module pnpr_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pnpr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pnpr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pnpr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output pnpr_pkg::t_cfg                      o_cfg
);
    import pnpr_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nib_wait_max <= RST_NIB_WAIT_MAX;
            r_cfg.max_length   <= RST_MAX_LENGTH;
            r_cfg.retry_limit  <= RST_RETRY_LIMIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NIB_WAIT_MAX: r_cfg.nib_wait_max <= pwdata[15:0];
                REG_MAX_LENGTH:   r_cfg.max_length   <= pwdata[15:0];
                REG_RETRY_LIMIT:  r_cfg.retry_limit  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NIB_WAIT_MAX: prdata = {16'd0, r_cfg.nib_wait_max};
            REG_MAX_LENGTH:   prdata = {16'd0, r_cfg.max_length};
            REG_RETRY_LIMIT:  prdata = {28'd0, r_cfg.retry_limit};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule : pnpr_cfg_regs

`default_nettype wire

FILE: sv/pnpr_core.sv
// frame state machine and result register of the receiver
// depends on pnpr_pkg and pnpr_if
`default_nettype none

module pnpr_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pnpr_pkg::t_cfg i_cfg,
    pnpr_in_if.sink             i_in,
    pnpr_out_if.source          o_out
);
    import pnpr_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_nib, n_nib;
    logic [4:0]  r_prev;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_sum, n_sum;
    logic [3:0]  r_low, n_low;
    logic [15:0] r_wait, n_wait;
    logic [3:0]  r_tally, n_tally;
    logic [4:0]  r_drive, n_drive;

    // result register
    logic        r_out_valid;
    logic [4:0]  r_port_drive;
    logic        r_data_valid;
    logic [7:0]  r_data_byte;
    logic        r_packet_done;
    t_pkt_status r_packet_status;
    logic [15:0] r_packet_length;
    logic        r_receiving;

    logic        accept;
    logic [4:0]  s;
    logic        stable, taken;
    logic [7:0]  nib_byte;
    logic [15:0] wait_inc, len_hi;
    logic        res_valid, res_done;
    logic [7:0]  res_byte;
    t_pkt_status res_status;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign s          = i_in.status_bits;
    assign stable     = (s == r_prev);
    assign taken      = stable && (r_nib ? s[4] : !s[4]);
    assign nib_byte   = {s[3:0], r_low};
    assign wait_inc   = r_wait + 16'd1;
    assign len_hi     = {nib_byte, r_len[7:0]};

    // next state
    always_comb begin
        n_phase = r_phase;
        n_nib   = r_nib;
        n_len   = r_len;
        n_count = r_count;
        n_sum   = r_sum;
        n_low   = r_low;
        n_wait  = r_wait;
        n_tally = r_tally;
        n_drive = r_drive;
        unique case (r_phase)
            PH_ERROR: begin
                if (s == ERROR_EXIT) n_phase = PH_IDLE;
            end
            PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CHECK: begin
                if (!taken) begin
                    n_wait = wait_inc;
                    if (wait_inc >= i_cfg.nib_wait_max) begin
                        n_wait = '0;
                        if (r_tally < i_cfg.retry_limit) begin
                            n_tally = r_tally + 4'd1;
                        end else begin
                            n_drive = DRIVE_NONE;
                            n_nib   = 1'b0;
                            n_phase = PH_ERROR;
                        end
                    end
                end else if (!r_nib) begin
                    n_low   = s[3:0];
                    n_drive = DRIVE_ACK;
                    n_nib   = 1'b1;
                    n_wait  = '0;
                end else begin
                    n_drive = DRIVE_NONE;
                    n_nib   = 1'b0;
                    n_wait  = '0;
                    case (r_phase)
                        PH_LEN_LO: begin
                            n_len   = {r_len[15:8], nib_byte};
                            n_phase = PH_LEN_HI;
                        end
                        PH_LEN_HI: begin
                            n_len = len_hi;
                            if (len_hi > i_cfg.max_length || len_hi < MIN_LENGTH) begin
                                n_phase = PH_ERROR;
                            end else begin
                                n_count = '0;
                                n_sum   = '0;
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            n_sum   = r_sum + nib_byte;
                            n_count = r_count + 16'd1;
                            if (n_count >= r_len) n_phase = PH_CHECK;
                        end
                        default: begin
                            n_phase = (nib_byte == r_sum) ? PH_IDLE : PH_ERROR;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (s == START_PATTERN) begin
                    n_drive = DRIVE_START;
                    n_phase = PH_LEN_LO;
                    n_nib   = 1'b0;
                    n_len   = '0;
                    n_count = '0;
                    n_sum   = '0;
                    n_wait  = '0;
                    n_tally = '0;
                end
            end
        endcase
    end

    // result fields of this tick
    always_comb begin
        res_valid  = 1'b0;
        res_byte   = '0;
        res_done   = 1'b0;
        res_status = PKT_OK;
        unique case (r_phase)
            PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CHECK: begin
                if (!taken) begin
                    if (wait_inc >= i_cfg.nib_wait_max
                        && !(r_tally < i_cfg.retry_limit)) begin
                        res_done   = 1'b1;
                        res_status = PKT_TIMEOUT;
                    end
                end else if (r_nib) begin
                    case (r_phase)
                        PH_LEN_HI: begin
                            if (len_hi > i_cfg.max_length || len_hi < MIN_LENGTH) begin
                                res_done   = 1'b1;
                                res_status = PKT_LENGTH;
                            end
                        end
                        PH_DATA: begin
                            res_valid = 1'b1;
                            res_byte  = nib_byte;
                        end
                        PH_CHECK: begin
                            res_done   = 1'b1;
                            res_status = (nib_byte == r_sum) ? PKT_OK : PKT_CHECKSUM;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_nib   <= 1'b0;
            r_prev  <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_low   <= '0;
            r_wait  <= '0;
            r_tally <= '0;
            r_drive <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_nib   <= n_nib;
            r_prev  <= s;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_low   <= n_low;
            r_wait  <= n_wait;
            r_tally <= n_tally;
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_port_drive    <= n_drive;
            r_data_valid    <= res_valid;
            r_data_byte     <= res_byte;
            r_packet_done   <= res_done;
            r_packet_status <= res_status;
            r_packet_length <= res_done ? n_len : 16'd0;
            r_receiving     <= (n_phase != PH_IDLE);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.port_drive    = r_port_drive;
    assign o_out.data_valid    = r_data_valid;
    assign o_out.data_byte     = r_data_byte;
    assign o_out.packet_done   = r_packet_done;
    assign o_out.packet_status = r_packet_status;
    assign o_out.packet_length = r_packet_length;
    assign o_out.receiving     = r_receiving;

    // a byte and a packet end never share one tick
    a_byte_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_data_valid && r_packet_done))
        else $error("data byte and packet end in one result");

    // a clean end leaves the packet, any error keeps the block in recovery
    a_done_receiving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_packet_done) |-> (r_receiving == (r_packet_status != PKT_OK)))
        else $error("receiving flag disagrees with packet status");

    // recovery always waits for a fresh low nibble
    a_error_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |-> !r_nib)
        else $error("nibble phase set in error recovery");

    // start pattern in idle opens a packet and acks it
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_IDLE && s == START_PATTERN)
        |=> (r_phase == PH_LEN_LO && r_drive == DRIVE_START))
        else $error("start pattern did not open a packet");

endmodule : pnpr_core

`default_nettype wire
